/* hw/rtl/gra_pkg.sv */
// ============================================================================
// gra_pkg: shared types and constants of the guillotine rectangle allocator
// Holds the cell count, rectangle and token records, and the result codes.
// ============================================================================
package gra_pkg;

    localparam int MAX_FREE = 64;
    localparam int IDXW     = $clog2(MAX_FREE);
    localparam int CNTW     = $clog2(MAX_FREE + 1);
    localparam int CW       = 15;
    localparam int AW       = 2 * CW;
    localparam int PW       = 14;
    localparam int TAGW     = 16;
    localparam int STW      = 3;

    localparam logic [CW-1:0] SIDE_MAX   = 15'd16384;
    localparam logic [CW-1:0] SIDE_RESET = 15'd1024;

    localparam logic [STW-1:0] ST_PLACED  = 3'd0;
    localparam logic [STW-1:0] ST_NOFIT   = 3'd1;
    localparam logic [STW-1:0] ST_TOOBIG  = 3'd2;
    localparam logic [STW-1:0] ST_LOST    = 3'd3;
    localparam logic [STW-1:0] ST_CLEARED = 3'd4;

    localparam logic CMD_CLEAR = 1'b0;

    typedef struct packed {
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } rect_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLR,
        OP_SET,
        OP_APP,
        OP_DEL
    } op_t;

    typedef struct packed {
        op_t            op;
        logic [IDXW-1:0] idx;
        rect_t          rect;
        logic [CW-1:0]  req_w;
        logic [CW-1:0]  req_h;
    } ctl_t;

    typedef struct packed {
        logic            valid;
        logic            found;
        logic [AW-1:0]   area;
        logic [IDXW-1:0] idx;
        rect_t           rect;
    } tok_t;

endpackage

/* hw/rtl/gra_cell.sv */
// ============================================================================
// gra_cell: one slot of the free list
// Holds one free rectangle, checks the passing search token against it and
// takes its neighbor's entry when an entry at or below its index is removed.
// ============================================================================
module gra_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [gra_pkg::IDXW-1:0] cell_idx,
    input  gra_pkg::ctl_t           ctl,
    input  gra_pkg::rect_t          nbr_rect,
    input  logic                    nbr_valid,
    input  gra_pkg::tok_t           tok_in,
    output gra_pkg::tok_t           tok_out,
    output gra_pkg::rect_t          rect,
    output logic                    valid
);
    import gra_pkg::*;

    rect_t         rect_reg, rect_next;
    logic          valid_reg, valid_next;
    logic [AW-1:0] area_reg;
    tok_t          tok_reg, tok_next;
    logic [CW-1:0] w, h;
    logic          hit, shift;

    assign w     = rect_reg.x1 - rect_reg.x0;
    assign h     = rect_reg.y1 - rect_reg.y0;
    assign hit   = (cell_idx == ctl.idx);
    assign shift = (cell_idx >= ctl.idx);

    always_comb
    begin
        rect_next  = rect_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_CLR:
            begin
                valid_next = (cell_idx == '0);
                rect_next  = ctl.rect;
            end
            OP_SET:
            begin
                if (hit)
                    rect_next = ctl.rect;
            end
            OP_APP:
            begin
                if (hit)
                begin
                    rect_next  = ctl.rect;
                    valid_next = 1'b1;
                end
            end
            OP_DEL:
            begin
                if (shift)
                begin
                    rect_next  = nbr_rect;
                    valid_next = nbr_valid;
                end
            end
            default:
            begin
                rect_next = rect_reg;
            end
        endcase
    end

    // take the token over when this entry fits and beats the best so far
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && valid_reg && (w >= ctl.req_w) && (h >= ctl.req_h) &&
            (!tok_in.found || (area_reg < tok_in.area)))
        begin
            tok_next.found = 1'b1;
            tok_next.area  = area_reg;
            tok_next.idx   = cell_idx;
            tok_next.rect  = rect_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
        area_reg <= AW'(w) * AW'(h);
    end

    assign tok_out = tok_reg;
    assign rect    = rect_reg;
    assign valid   = valid_reg;

endmodule

/* hw/rtl/guillotine_rect_allocator_top.sv */
// Usage: requests arrive on s_axis (tuser = command, 0 clear / 1 place;
// tdata = width, height, tag). Each request yields one result on m_axis
// (tuser = status; tdata = pos_x, pos_y, tag). The atlas side is written on
// the cfg channel while no request is in flight; it is always ready.
// A clear passes the clear and done states before its result. A place runs a
// search token down the row of MAX_FREE cells, one cell per cycle; when
// nothing fits it goes to the done state, after a trim or a removal through
// the update state, and when a strip is appended through update and append.
// A request rejected for size goes straight to done. One request is worked on
// at a time; the next one is accepted while the previous result still waits
// in the output register.
// Reset empties the free list and sets the side to 1024; a place before the
// first clear finds no fit. When the receiver stalls, hold the result in the
// output register and wait before loading the next one.
// ============================================================================
// guillotine_rect_allocator_top: online guillotine rectangle allocator
// Best-area-fit placement over a row of free-list cells.
// ============================================================================
module guillotine_rect_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // req_width[14:0], req_height[29:15], req_tag[45:30]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pos_x[13:0], pos_y[27:14], out_tag[43:28]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data        // atlas_side[14:0]
);
    import gra_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CLR  = 6'b000010,
        S_SRCH = 6'b000100,
        S_UPD  = 6'b001000,
        S_APP  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   side_reg;
    logic [CW-1:0]   req_w_reg, req_h_reg;
    logic [TAGW-1:0] tag_reg;
    logic [STW-1:0]  status_reg;
    logic [PW-1:0]   px_reg, py_reg;
    logic [CNTW-1:0] count_reg;
    tok_t            best_reg;
    logic            inj_reg;
    logic            out_valid_reg;
    logic [STW-1:0]  out_status_reg;
    logic [PW-1:0]   out_x_reg, out_y_reg;
    logic [TAGW-1:0] out_tag_reg;

    ctl_t            ctl;
    tok_t            tok [MAX_FREE+1];
    rect_t           crect [MAX_FREE];
    logic            cvalid [MAX_FREE];

    logic            in_acc, out_load, too_big, room;
    logic [CW-1:0]   in_w, in_h, bw, bh;
    logic            fit_w, fit_h;

    assign in_w   = s_axis_tdata[14:0];
    assign in_h   = s_axis_tdata[29:15];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign too_big = (in_w == '0) || (in_h == '0) || (in_w > side_reg) || (in_h > side_reg);
    assign cfg_ready = 1'b1;

    assign bw    = best_reg.rect.x1 - best_reg.rect.x0;
    assign bh    = best_reg.rect.y1 - best_reg.rect.y0;
    assign fit_w = (req_w_reg == bw);
    assign fit_h = (req_h_reg == bh);
    assign room  = (count_reg < CNTW'(MAX_FREE));
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // drive the cell row: clear, trim, append or remove
    always_comb
    begin
        ctl       = '0;
        ctl.op    = OP_NOP;
        ctl.idx   = best_reg.idx;
        ctl.rect  = best_reg.rect;
        ctl.req_w = req_w_reg;
        ctl.req_h = req_h_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ctl.op      = OP_CLR;
                ctl.rect.x0 = '0;
                ctl.rect.y0 = '0;
                ctl.rect.x1 = side_reg;
                ctl.rect.y1 = side_reg;
            end
            S_UPD:
            begin
                if (fit_w && fit_h)
                    ctl.op = OP_DEL;
                else if (fit_w)
                begin
                    ctl.op      = OP_SET;
                    ctl.rect.y0 = best_reg.rect.y0 + req_h_reg;
                end
                else
                begin
                    ctl.op      = OP_SET;
                    ctl.rect.x0 = best_reg.rect.x0 + req_w_reg;
                end
            end
            S_APP:
            begin
                ctl.op      = OP_APP;
                ctl.idx     = count_reg[IDXW-1:0];
                ctl.rect.y0 = best_reg.rect.y0 + req_h_reg;
                ctl.rect.x1 = best_reg.rect.x0 + req_w_reg;
            end
            default:
            begin
                ctl.op = OP_NOP;
            end
        endcase
    end

    // inject the search token at the head of the row
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = inj_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FREE; gi++)
        begin : g_cell
            rect_t nbr_r;
            logic  nbr_v;
            if (gi == MAX_FREE - 1)
            begin : g_last
                assign nbr_r = crect[gi];
                assign nbr_v = 1'b0;
            end
            else
            begin : g_mid
                assign nbr_r = crect[gi+1];
                assign nbr_v = cvalid[gi+1];
            end
            gra_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDXW'(gi)),
                .ctl      (ctl),
                .nbr_rect (nbr_r),
                .nbr_valid(nbr_v),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1]),
                .rect     (crect[gi]),
                .valid    (cvalid[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser[0] == CMD_CLEAR)
                        state_next = S_CLR;
                    else if (too_big)
                        state_next = S_DONE;
                    else
                        state_next = S_SRCH;
                end
            end
            S_CLR:
                state_next = S_DONE;
            S_SRCH:
            begin
                if (tok[MAX_FREE].valid)
                    state_next = tok[MAX_FREE].found ? S_UPD : S_DONE;
            end
            S_UPD:
                state_next = (!fit_w && !fit_h && room) ? S_APP : S_DONE;
            S_APP:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= SIDE_RESET;
            count_reg     <= '0;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= in_acc && (s_axis_tuser[0] != CMD_CLEAR) && !too_big;
            if (cfg_valid && cfg_ready)
                side_reg <= (cfg_data > SIDE_MAX) ? SIDE_MAX : cfg_data;
            if (state_reg == S_CLR)
                count_reg <= CNTW'(1);
            else if ((state_reg == S_UPD) && fit_w && fit_h)
                count_reg <= count_reg - CNTW'(1);
            else if (state_reg == S_APP)
                count_reg <= count_reg + CNTW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_w_reg  <= in_w;
            req_h_reg  <= in_h;
            tag_reg    <= s_axis_tdata[45:30];
            px_reg     <= '0;
            py_reg     <= '0;
            if (s_axis_tuser[0] == CMD_CLEAR)
                status_reg <= ST_CLEARED;
            else
                status_reg <= ST_TOOBIG;
        end
        if ((state_reg == S_SRCH) && tok[MAX_FREE].valid)
        begin
            best_reg <= tok[MAX_FREE];
            if (tok[MAX_FREE].found)
            begin
                status_reg <= ST_PLACED;
                px_reg     <= tok[MAX_FREE].rect.x0[PW-1:0];
                py_reg     <= tok[MAX_FREE].rect.y0[PW-1:0];
            end
            else
                status_reg <= ST_NOFIT;
        end
        if ((state_reg == S_UPD) && !fit_w && !fit_h && !room)
            status_reg <= ST_LOST;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_x_reg      <= px_reg;
            out_y_reg      <= py_reg;
            out_tag_reg    <= tag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_tag_reg, out_y_reg, out_x_reg};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the guillotine rectangle allocator
// Streams clear and place requests, predicts every result with a local
// best-area-fit free list, and compares results field by field in order.
// ============================================================================
module testbench;
    import gra_pkg::*;

    // One request as the driver presents it.
    typedef struct {
        logic          cmd;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic [15:0]   tag;
    } alloc_req_t;

    // One result as the block returns it.
    typedef struct {
        logic [STW-1:0] status;
        logic [PW-1:0]  x;
        logic [PW-1:0]  y;
        logic [15:0]    tag;
    } alloc_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // req_width[14:0], req_height[29:15], req_tag[45:30]
    logic [0:0]  s_axis_tuser;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // pos_x[13:0], pos_y[27:14], out_tag[43:28]
    logic [2:0]  m_axis_tuser;   // status[2:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;       // atlas_side[14:0]

    guillotine_rect_allocator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a copy of the free list and the side register.
    // ------------------------------------------------------------------
    rect_t         pred_rects [MAX_FREE];
    int            pred_count;
    logic [CW-1:0] pred_side;

    alloc_req_t    pending_reqs [$];   // filled by the stimulus, drained by the driver
    alloc_res_t    expected_results [$];
    int            error_count;
    int            idle_cycles;

    // Driver / sink control
    bit            drain_hold;         // stimulus asks the driver to stop offering
    bit            stall_toggle;       // stimulus flips it to start a long stall
    bit            stall_seen;
    int            sink_hold;          // forced long receiver stall, in cycles
    int            src_gap;
    int            sink_gap;

    localparam int WATCHDOG_LIMIT = 20000;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [CW-1:0] clip_side(input logic [CW-1:0] v);
        return (v > SIDE_MAX) ? SIDE_MAX : v;
    endfunction

    // Best-area-fit placement with guillotine split, or a clear; returns the result.
    function automatic alloc_res_t place_or_clear(input alloc_req_t r);
        alloc_res_t res;
        int         best;
        bit         found;
        logic [AW-1:0] min_area;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic [AW-1:0] a;
        rect_t      strip;
        res.status = ST_PLACED;
        res.x = '0;
        res.y = '0;
        res.tag = r.tag;
        best = 0;
        found = 0;
        min_area = '0;
        if (r.cmd == CMD_CLEAR) begin
            pred_rects[0] = '{x0: '0, y0: '0, x1: pred_side, y1: pred_side};
            pred_count = 1;
            res.status = ST_CLEARED;
            return res;
        end
        if (r.w == 0 || r.h == 0 || r.w > pred_side || r.h > pred_side) begin
            res.status = ST_TOOBIG;
            return res;
        end
        for (int i = 0; i < pred_count; i++) begin
            w = pred_rects[i].x1 - pred_rects[i].x0;
            h = pred_rects[i].y1 - pred_rects[i].y0;
            a = w * h;
            if (w >= r.w && h >= r.h && (!found || a < min_area)) begin
                found = 1;
                best = i;
                min_area = a;
            end
        end
        if (!found) begin
            res.status = ST_NOFIT;
            return res;
        end
        w = pred_rects[best].x1 - pred_rects[best].x0;
        h = pred_rects[best].y1 - pred_rects[best].y0;
        res.x = pred_rects[best].x0[PW-1:0];
        res.y = pred_rects[best].y0[PW-1:0];
        if (r.w == w && r.h == h) begin
            // exact fit: remove and keep order
            for (int i = best; i + 1 < pred_count; i++)
                pred_rects[i] = pred_rects[i+1];
            pred_count--;
        end else if (r.w == w) begin
            pred_rects[best].y0 = pred_rects[best].y0 + r.h;
        end else if (r.h == h) begin
            pred_rects[best].x0 = pred_rects[best].x0 + r.w;
        end else begin
            if (pred_count < MAX_FREE) begin
                strip.x0 = pred_rects[best].x0;
                strip.y0 = pred_rects[best].y0 + r.h;
                strip.x1 = pred_rects[best].x0 + r.w;
                strip.y1 = pred_rects[best].y1;
                pred_rects[pred_count] = strip;
                pred_count++;
            end else begin
                res.status = ST_LOST;
            end
            pred_rects[best].x0 = pred_rects[best].x0 + r.w;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer pending requests with random gaps; predict on accept.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        alloc_req_t nx;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                // Advance: predict the accepted request, then idle for a drawn gap.
                expected_results.insert(expected_results.size(),
                                        place_or_clear(pending_reqs.pop_front()));
                s_axis_tvalid <= 1'b0;
                src_gap       <= $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
            end else if (s_axis_tvalid) begin
                // hold the current request
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (!drain_hold && pending_reqs.size() > 0) begin
                nx = pending_reqs[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nx.cmd;
                s_axis_tdata  <= {2'b00, nx.tag, nx.h, nx.w};
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver stall, counted here on request of the stimulus.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sink_hold  <= 0;
            stall_seen <= 1'b0;
        end else if (stall_toggle != stall_seen) begin
            sink_hold  <= 400;
            stall_seen <= stall_toggle;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor / sink: random ready, forced long stalls, field checks.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        alloc_res_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, tag", m_axis_tdata[43:28], -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[13:0] !== want.x)
                        report_mismatch("pos_x", m_axis_tdata[13:0], want.x);
                    if (m_axis_tdata[27:14] !== want.y)
                        report_mismatch("pos_y", m_axis_tdata[27:14], want.y);
                    if (m_axis_tdata[43:28] !== want.tag)
                        report_mismatch("out_tag", m_axis_tdata[43:28], want.tag);
                end
                sink_gap <= $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
            end
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0 && !(m_axis_tvalid && m_axis_tready)) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(m_axis_tvalid && m_axis_tready) || sink_gap == 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no request or result accepted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input logic cmd, input int w, input int h);
        alloc_req_t r;
        r.cmd = cmd;
        r.w   = w[CW-1:0];
        r.h   = h[CW-1:0];
        r.tag = $urandom_range(0, 65535);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Wait until every queued request went in and every result came back,
    // then let the block settle before a register write.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_side(input int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[14:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        pred_side = clip_side(v[14:0]);
    endtask

    // A random place size: mostly small relative to the side, some full-range.
    function automatic int rand_dim(input int side);
        int sel;
        sel = $urandom_range(0, 9);
        if (side < 1 || sel == 0)
            return $urandom_range(0, 32767);
        if (sel < 3)
            return side;
        return $urandom_range(1, (side > 8) ? side / 4 : side);
    endfunction

    // Random batch: a clear, then places with an occasional clear; some sizes full-range.
    task automatic random_batch(input int n, input int side);
        push_req(CMD_CLEAR, $urandom_range(0, 32767), $urandom_range(0, 32767));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 40) == 0)
                push_req(CMD_CLEAR, 0, 0);
            else
                push_req(~CMD_CLEAR, rand_dim(side), rand_dim(side));
        end
    endtask

    initial begin
        int sides [6];
        drain_hold    = 0;
        stall_toggle  = 0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        pred_count    = 0;
        pred_side     = SIDE_RESET;
        foreach (pred_rects[i]) pred_rects[i] = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: place before clear, too big, zero size, extremes, all cuts.
        push_req(~CMD_CLEAR, 10, 10);
        push_req(~CMD_CLEAR, 2000, 5);
        push_req(CMD_CLEAR, 32767, 32767);
        push_req(~CMD_CLEAR, 0, 5);
        push_req(~CMD_CLEAR, 5, 0);
        push_req(~CMD_CLEAR, 1025, 1);
        push_req(~CMD_CLEAR, 1024, 100);   // full width: trim top
        push_req(~CMD_CLEAR, 100, 924);    // full height: trim left
        push_req(~CMD_CLEAR, 10, 20);      // general split with strip
        push_req(~CMD_CLEAR, 10, 904);     // fits strip exactly: remove
        push_req(~CMD_CLEAR, 914, 924);    // exact fit of remainder
        push_req(~CMD_CLEAR, 1, 1);        // no fit left
        push_req(CMD_CLEAR, 0, 0);
        push_req(~CMD_CLEAR, 1024, 1024);
        push_req(CMD_CLEAR, 0, 0);
        // Many small cuts in a row.
        for (int i = 0; i < 70; i++)
            push_req(~CMD_CLEAR, 1, 1);
        wait_idle();

        // Side extremes and a side change without clear.
        sides = '{1, 0, 16384, 32767, 7, 300};
        foreach (sides[k]) begin
            write_side(sides[k]);
            if (k == 2) begin
                // Side grows without clear: old list kept, new size check.
                push_req(~CMD_CLEAR, 2000, 2000);
                push_req(~CMD_CLEAR, 16384, 16384);
            end
            random_batch(k == 5 ? 150 : 40, pred_side);
            if (k == 4) begin
                // Long receiver stall while the sender keeps offering.
                @(posedge clk);
                stall_toggle = ~stall_toggle;
            end
            if (k == 3) begin
                // Sender pauses until every result is back.
                repeat (30) @(posedge clk);
                drain_hold = 1;
                while (expected_results.size() != 0 || s_axis_tvalid) @(posedge clk);
                drain_hold = 0;
                random_batch(30, pred_side);
            end
            wait_idle();
        end
        write_side(1024);
        random_batch(120, 1024);
        wait_idle();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
